### rtl/pplc_pkg.sv
package pplc_pkg;

    // register indexes on the configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_GOAL        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PROPORTIONAL_GAIN = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTEGRAL_GAIN     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACCUMULATOR_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_INVERTED    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_PHASE       = 3'd6;

    // operation codes of an input transaction
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_REINIT = 1'b1;

    // gain and limit formats
    localparam int GAIN_BITS    = 16;
    localparam int LIMIT_BITS   = 23;
    localparam int KP_FRAC_BITS = 12;
    localparam int KI_FRAC_BITS = 16;

    localparam logic [GAIN_BITS-1:0]  KP_RESET    = 16'd4096;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 23'd32768;

    // control of the stage between front end and loop core
    typedef struct packed {
        logic valid;
        logic reinit;
    } t_stage_ctl;

endpackage

### rtl/pi_phase_lock_controller.sv
// path: an accepted input transaction passes the input stage register, then the result register
// throughput: one transaction per cycle while the receiver does not stall; the integral and
//   command registers close their loop between the input stage and the result register
// reset (i_rst_n low, synchronous): registers to defaults (proportional gain 1.0, integral
//   gain 0, limit 180 deg), integral and command to zero, both stages empty
module pi_phase_lock_controller #(
    parameter int PHASE_BITS    = 16,
    parameter int INTEGRAL_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration port
    input  logic                                      i_cfg_wr_en,
    input  logic [pplc_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [((PHASE_BITS > pplc_pkg::LIMIT_BITS) ?
                   PHASE_BITS : pplc_pkg::LIMIT_BITS)-1:0] i_cfg_wdata,
    // input channel
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic                                      i_operation,
    input  logic signed [PHASE_BITS-1:0]              i_measured_phase,
    // result channel
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [PHASE_BITS-1:0]              o_phase_error,
    output logic signed [PHASE_BITS-1:0]              o_calibrated_phase,
    output logic signed [PHASE_BITS-1:0]              o_phase_command
);
    import pplc_pkg::*;

    logic signed [PHASE_BITS-1:0] r_phase_offset;
    logic signed [PHASE_BITS-1:0] r_phase_goal;
    logic [GAIN_BITS-1:0]         r_proportional_gain;
    logic [GAIN_BITS-1:0]         r_integral_gain;
    logic [LIMIT_BITS-1:0]        r_accumulator_limit;
    logic                         r_drive_inverted;
    logic signed [PHASE_BITS-1:0] r_start_phase;

    t_stage_ctl                   stage_ctl;
    logic signed [PHASE_BITS-1:0] stage_error;
    logic signed [PHASE_BITS-1:0] stage_calibrated;
    logic                         core_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_offset      <= '0;
            r_phase_goal        <= '0;
            r_proportional_gain <= KP_RESET;
            r_integral_gain     <= '0;
            r_accumulator_limit <= LIMIT_RESET;
            r_drive_inverted    <= 1'b0;
            r_start_phase       <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PHASE_OFFSET:      r_phase_offset      <= i_cfg_wdata[PHASE_BITS-1:0];
                REG_PHASE_GOAL:        r_phase_goal        <= i_cfg_wdata[PHASE_BITS-1:0];
                REG_PROPORTIONAL_GAIN: r_proportional_gain <= i_cfg_wdata[GAIN_BITS-1:0];
                REG_INTEGRAL_GAIN:     r_integral_gain     <= i_cfg_wdata[GAIN_BITS-1:0];
                REG_ACCUMULATOR_LIMIT: r_accumulator_limit <= i_cfg_wdata[LIMIT_BITS-1:0];
                REG_DRIVE_INVERTED:    r_drive_inverted    <= i_cfg_wdata[0];
                REG_START_PHASE:       r_start_phase       <= i_cfg_wdata[PHASE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stage: calibration and phase error
    pplc_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_measured_phase (i_measured_phase),
        .i_phase_offset   (r_phase_offset),
        .i_phase_goal     (r_phase_goal),
        .i_core_ready     (core_ready),
        .o_ctl            (stage_ctl),
        .o_error          (stage_error),
        .o_calibrated     (stage_calibrated)
    );

    // loop core: integral, command and result register
    pplc_core #(
        .PHASE_BITS    (PHASE_BITS),
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (stage_ctl),
        .i_error             (stage_error),
        .i_calibrated        (stage_calibrated),
        .o_ready             (core_ready),
        .i_proportional_gain (r_proportional_gain),
        .i_integral_gain     (r_integral_gain),
        .i_accumulator_limit (r_accumulator_limit),
        .i_drive_inverted    (r_drive_inverted),
        .i_start_phase       (r_start_phase),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_phase_error       (o_phase_error),
        .o_calibrated_phase  (o_calibrated_phase),
        .o_phase_command     (o_phase_command)
    );

endmodule

### rtl/pplc_front.sv
module pplc_front #(
    parameter int PHASE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic signed [PHASE_BITS-1:0]  i_measured_phase,
    // configuration
    input  logic signed [PHASE_BITS-1:0]  i_phase_offset,
    input  logic signed [PHASE_BITS-1:0]  i_phase_goal,
    // towards the loop core
    input  logic                          i_core_ready,
    output pplc_pkg::t_stage_ctl          o_ctl,
    output logic signed [PHASE_BITS-1:0]  o_error,
    output logic signed [PHASE_BITS-1:0]  o_calibrated
);
    import pplc_pkg::*;

    t_stage_ctl                   r_ctl;
    logic signed [PHASE_BITS-1:0] r_error;
    logic signed [PHASE_BITS-1:0] r_calibrated;
    logic signed [PHASE_BITS-1:0] n_error;
    logic signed [PHASE_BITS-1:0] n_calibrated;
    logic                         load;

    // stage is free when empty or when the core takes its content
    assign o_stall = r_ctl.valid & ~i_core_ready;
    assign load    = i_valid & ~o_stall;

    // calibration and error, both wrapped modulo a full turn
    always_comb begin
        if (i_operation == OP_REINIT) begin
            n_calibrated = '0;
            n_error      = '0;
        end else begin
            n_calibrated = i_measured_phase - i_phase_offset;
            n_error      = n_calibrated - i_phase_goal;
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (load) begin
            r_ctl.valid  <= 1'b1;
            r_ctl.reinit <= (i_operation == OP_REINIT);
        end else if (i_core_ready) begin
            r_ctl.valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_error      <= n_error;
            r_calibrated <= n_calibrated;
        end
    end

    assign o_ctl        = r_ctl;
    assign o_error      = r_error;
    assign o_calibrated = r_calibrated;

endmodule

### rtl/pplc_core.sv
module pplc_core #(
    parameter int PHASE_BITS    = 16,
    parameter int INTEGRAL_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // from the front end
    input  pplc_pkg::t_stage_ctl                   i_ctl,
    input  logic signed [PHASE_BITS-1:0]           i_error,
    input  logic signed [PHASE_BITS-1:0]           i_calibrated,
    output logic                                   o_ready,
    // configuration
    input  logic [pplc_pkg::GAIN_BITS-1:0]         i_proportional_gain,
    input  logic [pplc_pkg::GAIN_BITS-1:0]         i_integral_gain,
    input  logic [pplc_pkg::LIMIT_BITS-1:0]        i_accumulator_limit,
    input  logic                                   i_drive_inverted,
    input  logic signed [PHASE_BITS-1:0]           i_start_phase,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [PHASE_BITS-1:0]           o_phase_error,
    output logic signed [PHASE_BITS-1:0]           o_calibrated_phase,
    output logic signed [PHASE_BITS-1:0]           o_phase_command
);
    import pplc_pkg::*;

    // working width covers integral, both unscaled products and twice the limit
    localparam int WIDE_A    = (INTEGRAL_BITS > PHASE_BITS + 5) ? INTEGRAL_BITS : PHASE_BITS + 5;
    localparam int WIDE_B    = (WIDE_A > LIMIT_BITS + 2) ? WIDE_A : LIMIT_BITS + 2;
    localparam int PROD_BITS = PHASE_BITS + GAIN_BITS + 1;
    localparam int WORK_BITS = (WIDE_B + 3 > PROD_BITS + 1) ? WIDE_B + 3 : PROD_BITS + 1;

    localparam logic signed [WORK_BITS-1:0] LIMIT_FLOOR = WORK_BITS'(1) <<< (PHASE_BITS - 2);
    localparam logic signed [WORK_BITS-1:0] KP_HALF     = WORK_BITS'(1) <<< (KP_FRAC_BITS - 1);
    localparam logic signed [WORK_BITS-1:0] KI_HALF     = WORK_BITS'(1) <<< (KI_FRAC_BITS - 1);

    logic                            r_out_valid;
    logic signed [PHASE_BITS-1:0]    r_phase_error;
    logic signed [PHASE_BITS-1:0]    r_calibrated;
    logic signed [PHASE_BITS-1:0]    r_phase_command;
    logic signed [INTEGRAL_BITS-1:0] r_integral;
    logic signed [PHASE_BITS-1:0]    r_command;

    logic                            advance;
    logic signed [PROD_BITS-1:0]     ki_prod;
    logic signed [PROD_BITS-1:0]     kp_prod;
    logic signed [WORK_BITS-1:0]     ki_term;
    logic signed [WORK_BITS-1:0]     kp_term;
    logic signed [WORK_BITS-1:0]     limit_raw;
    logic signed [WORK_BITS-1:0]     limit_eff;
    logic signed [WORK_BITS-1:0]     acc;
    logic signed [WORK_BITS-1:0]     acc_wrapped;
    logic signed [WORK_BITS-1:0]     ctl;
    logic signed [WORK_BITS-1:0]     ctl_dir;
    logic signed [WORK_BITS-1:0]     start_wide;
    logic signed [INTEGRAL_BITS-1:0] n_integral;
    logic signed [PHASE_BITS-1:0]    n_command;

    // result register is free when empty or taken this cycle
    assign o_ready = ~r_out_valid | ~i_stall;
    assign advance = i_ctl.valid & o_ready;

    // gain products, rounded half up
    assign ki_prod = $signed({1'b0, i_integral_gain}) * i_error;
    assign kp_prod = $signed({1'b0, i_proportional_gain}) * i_error;
    assign ki_term = (WORK_BITS'(ki_prod) + KI_HALF) >>> KI_FRAC_BITS;
    assign kp_term = (WORK_BITS'(kp_prod) + KP_HALF) >>> KP_FRAC_BITS;

    // limit held at no less than a quarter turn
    assign limit_raw = $signed({{(WORK_BITS - LIMIT_BITS){1'b0}}, i_accumulator_limit});
    assign limit_eff = (limit_raw < LIMIT_FLOOR) ? LIMIT_FLOOR : limit_raw;

    assign start_wide = WORK_BITS'(i_start_phase);

    // integral with one wrap correction, then proportional path and sign; reinitialize loads the start phase
    always_comb begin
        acc = WORK_BITS'(r_integral) + ki_term;
        if (acc > limit_eff) begin
            acc_wrapped = acc - (limit_eff <<< 1);
        end else if (acc <= -limit_eff) begin
            acc_wrapped = acc + (limit_eff <<< 1);
        end else begin
            acc_wrapped = acc;
        end
        ctl     = kp_term + WORK_BITS'($signed(acc_wrapped[INTEGRAL_BITS-1:0]));
        ctl_dir = i_drive_inverted ? -ctl : ctl;
        if (i_ctl.reinit) begin
            n_integral = start_wide[INTEGRAL_BITS-1:0];
            n_command  = i_start_phase;
        end else begin
            n_integral = acc_wrapped[INTEGRAL_BITS-1:0];
            n_command  = ctl_dir[PHASE_BITS-1:0];
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_command  <= '0;
        end else if (advance) begin
            r_integral <= n_integral;
            r_command  <= n_command;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_ctl.valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_phase_error   <= i_error;
            r_calibrated    <= i_calibrated;
            r_phase_command <= n_command;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_phase_error      = r_phase_error;
    assign o_calibrated_phase = r_calibrated;
    assign o_phase_command    = r_phase_command;

    // reinitialize loads the start phase and gives zero error fields
    a_reinit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && i_ctl.reinit) |=> (r_command == $past(i_start_phase)
            && r_phase_error == '0 && r_calibrated == '0))
        else $error("reinitialize did not load the start phase");

    // loop state moves only with a transaction into the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_integral) && $stable(r_command)))
        else $error("loop state changed without a transaction");

    // a waiting result is never dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result lost");

    // a shown command always matches the stored command
    a_command_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_phase_command == r_command))
        else $error("result command differs from loop state");

endmodule

### dv/tb_pi_phase_lock_controller.sv
`timescale 1ns / 100ps

module tb_pi_phase_lock_controller;
    import pplc_pkg::*;

    localparam int PHASE_W       = 16;
    localparam int INTEG_W       = 24;
    localparam int CFG_DATA_BITS = (PHASE_W > LIMIT_BITS) ? PHASE_W : LIMIT_BITS;
    localparam longint MIN_LIMIT = longint'(1) <<< (PHASE_W - 2);
    localparam int SETTLE_CYCLES = 4;
    localparam int N_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef logic [CFG_DATA_BITS-1:0] t_cfg_word;

    typedef struct packed {
        logic [PHASE_W-1:0] err;
        logic [PHASE_W-1:0] cal;
        logic [PHASE_W-1:0] cmd;
    } t_lock_result;

    typedef enum {ROW_WRITE, ROW_ITEM} t_row_kind;
    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_INDEX_BITS-1:0] index;
        t_cfg_word                 data;
        logic                      op;
        logic [PHASE_W-1:0]        phase;
        bit                        typed;
        t_lock_result              res;
    } t_plan_row;

    // dut signals
    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    t_cfg_word                 i_cfg_wdata;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_operation;
    logic signed [PHASE_W-1:0] i_measured_phase;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [PHASE_W-1:0] o_phase_error;
    logic signed [PHASE_W-1:0] o_calibrated_phase;
    logic signed [PHASE_W-1:0] o_phase_command;

    // loop model: register copies and state
    logic signed [PHASE_W-1:0] cfg_offset;
    logic signed [PHASE_W-1:0] cfg_goal;
    logic [GAIN_BITS-1:0]      cfg_kp;
    logic [GAIN_BITS-1:0]      cfg_ki;
    logic [LIMIT_BITS-1:0]     cfg_limit;
    logic                      cfg_invert;
    logic signed [PHASE_W-1:0] cfg_start;
    logic signed [INTEG_W-1:0] integ_model;
    logic signed [PHASE_W-1:0] cmd_model;

    t_lock_result pending_results[$];
    t_plan_row    plan[$];
    int           mismatch_count = 0;
    t_rx_mode     rx_mode = RX_OPEN;
    int           rx_cycle = 0;

    pi_phase_lock_controller #(
        .PHASE_BITS    (PHASE_W),
        .INTEGRAL_BITS (INTEG_W)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_measured_phase   (i_measured_phase),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_phase_error      (o_phase_error),
        .o_calibrated_phase (o_calibrated_phase),
        .o_phase_command    (o_phase_command)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // rounded right shift, ties toward plus infinity
    function automatic longint round_shr(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input t_cfg_word data);
        case (idx)
            REG_PHASE_OFFSET:      cfg_offset = data[PHASE_W-1:0];
            REG_PHASE_GOAL:        cfg_goal   = data[PHASE_W-1:0];
            REG_PROPORTIONAL_GAIN: cfg_kp     = data[GAIN_BITS-1:0];
            REG_INTEGRAL_GAIN:     cfg_ki     = data[GAIN_BITS-1:0];
            REG_ACCUMULATOR_LIMIT: cfg_limit  = data[LIMIT_BITS-1:0];
            REG_DRIVE_INVERTED:    cfg_invert = data[0];
            REG_START_PHASE:       cfg_start  = data[PHASE_W-1:0];
            default: ;
        endcase
    endfunction

    // expected result and next loop state for one accepted transaction
    function automatic t_lock_result predict_lock(input logic op,
                                                  input logic signed [PHASE_W-1:0] meas);
        t_lock_result              r;
        logic signed [PHASE_W-1:0] cal16;
        logic signed [PHASE_W-1:0] err16;
        longint                    lim;
        longint                    acc;
        longint                    ctl;
        r = '0;
        if (op == OP_REINIT) begin
            integ_model = cfg_start;
            cmd_model   = cfg_start;
        end else begin
            lim = longint'(cfg_limit);
            if (lim < MIN_LIMIT) lim = MIN_LIMIT;
            // circular subtraction wraps at the phase width
            cal16 = meas - cfg_offset;
            err16 = cal16 - cfg_goal;
            acc = longint'(integ_model)
                + round_shr(longint'(cfg_ki) * longint'(err16), KI_FRAC_BITS);
            // single wrap correction of twice the limit
            if (acc > lim) begin
                acc = acc - 2 * lim;
            end else if (acc <= -lim) begin
                acc = acc + 2 * lim;
            end
            integ_model = acc[INTEG_W-1:0];
            ctl = round_shr(longint'(cfg_kp) * longint'(err16), KP_FRAC_BITS)
                + longint'(integ_model);
            if (cfg_invert) ctl = -ctl;
            cmd_model = ctl[PHASE_W-1:0];
            r.err = err16;
            r.cal = cal16;
        end
        r.cmd = cmd_model;
        return r;
    endfunction

    function automatic void plan_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                       input t_cfg_word data);
        t_plan_row row;
        row = '{kind: ROW_WRITE, index: idx, data: data, op: OP_UPDATE, phase: '0,
                typed: 1'b0, res: '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic op, input logic [PHASE_W-1:0] phase,
                                      input bit typed = 1'b0,
                                      input logic [PHASE_W-1:0] e_err = '0,
                                      input logic [PHASE_W-1:0] e_cal = '0,
                                      input logic [PHASE_W-1:0] e_cmd = '0);
        t_plan_row row;
        row = '{kind: ROW_ITEM, index: '0, data: '0, op: op, phase: phase,
                typed: typed, res: '{e_err, e_cal, e_cmd}};
        plan.push_back(row);
    endfunction

    // register write while the loop is idle
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input t_cfg_word data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // offer one transaction and hold it until accepted
    task automatic push_item(input logic op, input logic [PHASE_W-1:0] phase,
                             input bit typed = 1'b0, input t_lock_result typed_res = '0);
        t_lock_result predicted;
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_measured_phase <= phase;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = predict_lock(op, phase);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic flag_result(input string why, input t_lock_result want,
                               input t_lock_result got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected err %0d cal %0d cmd %0d, got err %0d cal %0d cmd %0d",
                     $realtime, why, $signed(want.err), $signed(want.cal), $signed(want.cmd),
                     $signed(got.err), $signed(got.cal), $signed(got.cmd));
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:  i_stall <= ((rx_cycle % 9) < 4);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_lock_result got;
        t_lock_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            got = '{o_phase_error, o_calibrated_phase, o_phase_command};
            if (pending_results.size() == 0) begin
                flag_result("result with no transaction pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.err !== want.err || got.cal !== want.cal || got.cmd !== want.cmd)
                    flag_result("result mismatch", want, got);
            end
        end
    end

    // stimulus
    initial begin
        logic [GAIN_BITS-1:0]  kp;
        logic [GAIN_BITS-1:0]  ki;
        logic [LIMIT_BITS-1:0] lim;
        logic                  op;
        int                    burst_left;
        int                    gap;
        int                    pause_at;
        bit                    steady;

        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = REG_PHASE_OFFSET;
        i_cfg_wdata      = '0;
        i_valid          = 1'b0;
        i_operation      = OP_UPDATE;
        i_measured_phase = '0;

        cfg_offset  = '0;
        cfg_goal    = '0;
        cfg_kp      = KP_RESET;
        cfg_ki      = '0;
        cfg_limit   = LIMIT_RESET;
        cfg_invert  = 1'b0;
        cfg_start   = '0;
        integ_model = '0;
        cmd_model   = '0;

        // directed plan: unity gain after reset passes the sample straight through
        plan_item(OP_UPDATE, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        plan_item(OP_UPDATE, 16'h7fff, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
        plan_item(OP_UPDATE, 16'h8000, 1'b1, 16'h8000, 16'h8000, 16'h8000);
        plan_item(OP_UPDATE, 16'hffff, 1'b1, 16'hffff, 16'hffff, 16'hffff);
        plan_item(OP_UPDATE, 16'h0001, 1'b1, 16'h0001, 16'h0001, 16'h0001);
        plan_item(OP_REINIT, 16'h5555, 1'b1, 16'h0000, 16'h0000, 16'h0000);
        // offset at the negative extreme, calibrated phase wraps
        plan_write(REG_PHASE_OFFSET, t_cfg_word'(16'h8000));
        plan_item(OP_UPDATE, 16'h0000);
        plan_item(OP_UPDATE, 16'h7fff);
        // full gains, limit below ninety degrees, inverted drive
        plan_write(REG_PHASE_GOAL, t_cfg_word'(16'h7fff));
        plan_write(REG_PROPORTIONAL_GAIN, t_cfg_word'(16'hffff));
        plan_write(REG_INTEGRAL_GAIN, t_cfg_word'(16'hffff));
        plan_write(REG_ACCUMULATOR_LIMIT, '0);
        plan_write(REG_DRIVE_INVERTED, t_cfg_word'(1'b1));
        plan_write(REG_START_PHASE, t_cfg_word'(16'h8000));
        // start phase lies outside the accumulator limit, takes several updates to return
        plan_item(OP_REINIT, 16'haaaa, 1'b1, 16'h0000, 16'h0000, 16'h8000);
        plan_item(OP_UPDATE, 16'h7fff);
        plan_item(OP_UPDATE, 16'h0000);
        plan_item(OP_UPDATE, 16'h8000);
        plan_item(OP_UPDATE, 16'h1234);
        plan_write(REG_ACCUMULATOR_LIMIT, t_cfg_word'(23'd16384));
        plan_write(REG_PROPORTIONAL_GAIN, '0);
        plan_write(REG_DRIVE_INVERTED, '0);
        plan_item(OP_UPDATE, 16'h4000);
        plan_item(OP_UPDATE, 16'hc000);
        plan_item(OP_UPDATE, 16'h7fff);
        // widest limit, integral holds the start phase untouched
        plan_write(REG_ACCUMULATOR_LIMIT, t_cfg_word'(23'h7fffff));
        plan_write(REG_START_PHASE, t_cfg_word'(16'h7fff));
        plan_write(REG_PHASE_OFFSET, '0);
        plan_write(REG_PHASE_GOAL, '0);
        plan_write(REG_PROPORTIONAL_GAIN, t_cfg_word'(KP_RESET));
        plan_write(REG_INTEGRAL_GAIN, '0);
        plan_item(OP_REINIT, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h7fff);
        plan_item(OP_UPDATE, 16'h8000);
        plan_write(REG_INTEGRAL_GAIN, t_cfg_word'(16'hffff));
        plan_item(OP_UPDATE, 16'h7fff);
        plan_item(OP_UPDATE, 16'h7fff);
        plan_item(OP_UPDATE, 16'h7fff);

        // reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        rx_mode = RX_LIGHT;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain_results();
                cfg_write(plan[i].index, plan[i].data);
            end else begin
                push_item(plan[i].op, plan[i].phase, plan[i].typed, plan[i].res);
            end
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            case ($urandom_range(0, 3))
                0:       kp = '0;
                1:       kp = '1;
                2:       kp = KP_RESET;
                default: kp = GAIN_BITS'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       ki = '0;
                1:       ki = '1;
                2:       ki = GAIN_BITS'($urandom_range(0, 255));
                default: ki = GAIN_BITS'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       lim = 23'd16384;
                1:       lim = '1;
                2:       lim = LIMIT_BITS'($urandom_range(16384, 8388607));
                3:       lim = LIMIT_BITS'($urandom_range(0, 16383));
                default: lim = LIMIT_BITS'($urandom_range(16384, 65536));
            endcase
            // fixed extremes: wrapping integral, then a wide one, then a lowered limit
            if (ph == 0) begin
                kp  = '1;
                ki  = '1;
                lim = 23'd16384;
            end else if (ph == 1) begin
                kp  = '0;
                ki  = '1;
                lim = '1;
            end else if (ph == 2) begin
                lim = '0;
            end
            cfg_write(REG_PHASE_OFFSET, t_cfg_word'(PHASE_W'($urandom())));
            cfg_write(REG_PHASE_GOAL, t_cfg_word'(PHASE_W'($urandom())));
            cfg_write(REG_PROPORTIONAL_GAIN, t_cfg_word'(kp));
            cfg_write(REG_INTEGRAL_GAIN, t_cfg_word'(ki));
            cfg_write(REG_ACCUMULATOR_LIMIT, t_cfg_word'(lim));
            cfg_write(REG_DRIVE_INVERTED, t_cfg_word'($urandom_range(0, 1)));
            cfg_write(REG_START_PHASE, t_cfg_word'(PHASE_W'($urandom())));

            rx_mode    = t_rx_mode'(ph % 4);
            steady     = (ph % 3 == 1);
            burst_left = $urandom_range(1, 16);
            pause_at   = $urandom_range(20, ITEMS_PER_PHASE - 20);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = ($urandom_range(0, 19) == 0) ? OP_REINIT : OP_UPDATE;
                push_item(op, PHASE_W'($urandom()));
                if (n == pause_at) begin
                    drain_results();
                end else if (!steady) begin
                    if (burst_left == 0) begin
                        gap = $urandom_range(1, 6);
                        i_valid <= 1'b0;
                        repeat (gap) @(negedge i_clk);
                        burst_left = $urandom_range(1, 16);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
